@@ rtl/moc_pkg.sv @@
// ---------------------------------------------------------------------------
// Microwave oven controller package
// Shared types, constants and display tables of the oven controller.
// ---------------------------------------------------------------------------
package moc_pkg;

    localparam int FIFO_DEPTH = 2;

    localparam logic [7:0] DEBOUNCE_RESET = 8'd25;
    localparam logic [9:0] TPS_RESET = 10'd1000;
    localparam logic [9:0] BEEP_RESET = 10'd250;
    localparam logic [3:0] PRESET_QUICK_RESET = 4'd5;
    localparam logic [3:0] PRESET_POPCORN_RESET = 4'd7;
    localparam logic [3:0] PRESET_BEVERAGE_RESET = 4'd3;
    localparam logic [3:0] PRESET_DEFROST_RESET = 4'd9;
    localparam logic [3:0] SECONDS_RESET = 4'd5;
    localparam logic [3:0] SECONDS_MAX = 4'd9;

    localparam logic [7:0] TONE_START = 8'd255;
    localparam logic [7:0] TONE_PAUSE = 8'd155;
    localparam logic [7:0] TONE_POWER = 8'd195;

    typedef enum logic [2:0] {
        CFG_DEBOUNCE_TICKS   = 3'd0,
        CFG_TICKS_PER_SECOND = 3'd1,
        CFG_BEEP_TICKS       = 3'd2,
        CFG_PRESET_QUICK     = 3'd3,
        CFG_PRESET_POPCORN   = 3'd4,
        CFG_PRESET_BEVERAGE  = 3'd5,
        CFG_PRESET_DEFROST   = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_PAUSE = 2'd2
    } cook_state_t;

    typedef enum logic [1:0] {
        PWR_LOW  = 2'd0,
        PWR_MID  = 2'd1,
        PWR_HIGH = 2'd2
    } power_step_t;

    // Classified tick handed from the front end to the back end.
    typedef struct packed {
        logic       start_evt;
        logic       pause_evt;
        logic [1:0] mode_switch;
        logic       power_press;
    } evt_t;

    typedef struct packed {
        logic [9:0]      ticks_per_second;
        logic [9:0]      beep_ticks;
        logic [3:0][3:0] preset;
    } back_cfg_t;

    // Result item, first field in the highest bits.
    typedef struct packed {
        logic [3:0] time_left;
        logic [1:0] cook_state;
        logic [7:0] buzzer_period;
        logic       buzzer_on;
        logic [3:0] mode_leds;
        logic [2:0] power_leds;
        logic       digit_select;
        logic [6:0] segments;
    } result_t;

    function automatic logic [6:0] digit_pattern(input logic [3:0] value);
        logic [6:0] pat;
        case (value)
            4'd0: pat = 7'd63;
            4'd1: pat = 7'd6;
            4'd2: pat = 7'd91;
            4'd3: pat = 7'd79;
            4'd4: pat = 7'd102;
            4'd5: pat = 7'd109;
            4'd6: pat = 7'd125;
            4'd7: pat = 7'd7;
            4'd8: pat = 7'd127;
            default: pat = 7'd111;
        endcase
        return pat;
    endfunction

    function automatic logic [6:0] mode_pattern(input logic [1:0] mode);
        logic [6:0] pat;
        case (mode)
            2'd0: pat = 7'd103;
            2'd1: pat = 7'd115;
            2'd2: pat = 7'd124;
            default: pat = 7'd94;
        endcase
        return pat;
    endfunction

    function automatic logic [2:0] power_pattern(input power_step_t step);
        logic [2:0] pat;
        case (step)
            PWR_LOW: pat = 3'b100;
            PWR_MID: pat = 3'b110;
            default: pat = 3'b111;
        endcase
        return pat;
    endfunction

endpackage

@@ rtl/moc_front.sv @@
// ---------------------------------------------------------------------------
// Oven controller front end
// Debounces the start and pause buttons and turns each tick into an event.
// ---------------------------------------------------------------------------
module moc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic              start_level,
    input  logic              pause_level,
    input  logic [1:0]        mode_switch,
    input  logic              power_press,
    input  logic [7:0]        debounce_ticks,
    output moc_pkg::evt_t     evt
);

    logic [1:0]      candidate_reg, candidate_next;
    logic [1:0]      reported_reg, reported_next;
    logic [1:0][7:0] stable_reg, stable_next;
    logic [1:0]      level;
    logic [1:0]      fall;

    assign level = {pause_level, start_level};

    always_comb begin
        candidate_next = candidate_reg;
        reported_next  = reported_reg;
        stable_next    = stable_reg;
        fall           = 2'b00;
        for (int b = 0; b < 2; b++) begin
            if (level[b] == candidate_reg[b]) begin
                if (stable_reg[b] != 8'hFF) begin
                    stable_next[b] = stable_reg[b] + 8'd1;
                end
            end else begin
                stable_next[b]    = 8'd0;
                candidate_next[b] = level[b];
            end
            if (stable_next[b] >= debounce_ticks) begin
                fall[b]          = reported_reg[b] & ~candidate_next[b];
                reported_next[b] = candidate_next[b];
            end
        end
    end

    assign evt.start_evt   = fall[0];
    assign evt.pause_evt   = fall[1];
    assign evt.mode_switch = mode_switch;
    assign evt.power_press = power_press;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            candidate_reg <= '0;
            reported_reg  <= '0;
            stable_reg    <= '0;
        end else if (push) begin
            candidate_reg <= candidate_next;
            reported_reg  <= reported_next;
            stable_reg    <= stable_next;
        end
    end

endmodule

@@ rtl/moc_fifo.sv @@
// ---------------------------------------------------------------------------
// Oven controller event queue
// Short first-in first-out queue between the front and back ends.
// ---------------------------------------------------------------------------
module moc_fifo #(
    parameter int DEPTH = moc_pkg::FIFO_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  moc_pkg::evt_t push_data,
    input  logic          pop,
    output moc_pkg::evt_t pop_data,
    output logic          full,
    output logic          empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_C = PW'(DEPTH - 1);

    moc_pkg::evt_t      store_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;

    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("event queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("event queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("event queue count beyond depth");
`endif

endmodule

@@ rtl/moc_back.sv @@
// ---------------------------------------------------------------------------
// Oven controller back end
// Runs the cooking state machine, timers and beeper, and holds the result.
// ---------------------------------------------------------------------------
module moc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               evt_avail,
    input  moc_pkg::evt_t      evt,
    output logic               pop,
    input  moc_pkg::back_cfg_t cfg,
    output logic               m_tvalid,
    input  logic               m_tready,
    output moc_pkg::result_t   result
);

    moc_pkg::cook_state_t state_reg, state_next;
    moc_pkg::power_step_t power_reg, power_next;
    logic [3:0]           secs_reg, secs_next;
    logic [1:0]           mode_reg, mode_next;
    logic [1:0]           last_sw_reg, last_sw_next;
    logic [9:0]           tick_reg, tick_next;
    logic [9:0]           beep_cnt_reg, beep_cnt_next;
    logic                 beep_on_reg, beep_on_next;
    logic [7:0]           tone_reg, tone_next;
    logic                 toggle_reg, toggle_next;
    logic                 valid_reg;
    moc_pkg::result_t     result_reg, result_next;
    logic                 sec_evt;
    logic [3:0]           preset_sat;

    assign pop      = evt_avail && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign result   = result_reg;

    assign preset_sat = (cfg.preset[evt.mode_switch] > moc_pkg::SECONDS_MAX)
                        ? moc_pkg::SECONDS_MAX : cfg.preset[evt.mode_switch];

    always_comb begin
        state_next    = state_reg;
        power_next    = power_reg;
        secs_next     = secs_reg;
        mode_next     = mode_reg;
        last_sw_next  = last_sw_reg;
        toggle_next   = ~toggle_reg;
        beep_on_next  = beep_on_reg;
        tone_next     = tone_reg;
        sec_evt       = 1'b0;

        tick_next = tick_reg + 10'd1;
        if (tick_next >= cfg.ticks_per_second) begin
            sec_evt   = 1'b1;
            tick_next = '0;
        end
        beep_cnt_next = beep_cnt_reg + 10'd1;
        if (beep_cnt_next >= cfg.beep_ticks) begin
            beep_cnt_next = '0;
            beep_on_next  = 1'b0;
        end

        if (evt.power_press) begin
            case (power_reg)
                moc_pkg::PWR_LOW: power_next = moc_pkg::PWR_MID;
                moc_pkg::PWR_MID: power_next = moc_pkg::PWR_HIGH;
                default:          power_next = moc_pkg::PWR_LOW;
            endcase
            beep_on_next  = 1'b1;
            beep_cnt_next = '0;
            tone_next     = moc_pkg::TONE_POWER;
        end

        case (state_reg)
            moc_pkg::ST_IDLE: begin
                mode_next    = evt.mode_switch;
                secs_next    = preset_sat;
                last_sw_next = evt.mode_switch;
                if (evt.start_evt) begin
                    beep_on_next  = 1'b1;
                    beep_cnt_next = '0;
                    tone_next     = moc_pkg::TONE_START;
                    tick_next     = '0;
                    state_next    = moc_pkg::ST_RUN;
                end
            end
            moc_pkg::ST_RUN: begin
                if (sec_evt) begin
                    if (secs_reg != 4'd0) begin
                        secs_next = secs_reg - 4'd1;
                    end else if (evt.mode_switch != last_sw_reg) begin
                        last_sw_next = evt.mode_switch;
                        state_next   = moc_pkg::ST_IDLE;
                    end
                end
                if (evt.start_evt) begin
                    tick_next     = '0;
                    beep_on_next  = 1'b1;
                    beep_cnt_next = '0;
                    tone_next     = moc_pkg::TONE_START;
                    secs_next     = (secs_next < moc_pkg::SECONDS_MAX)
                                    ? secs_next + 4'd1 : moc_pkg::SECONDS_MAX;
                end
                if (evt.pause_evt) begin
                    tick_next     = '0;
                    beep_on_next  = 1'b1;
                    beep_cnt_next = '0;
                    tone_next     = moc_pkg::TONE_PAUSE;
                    state_next    = moc_pkg::ST_PAUSE;
                end
            end
            default: begin
                if (evt.pause_evt) begin
                    tick_next     = '0;
                    beep_on_next  = 1'b1;
                    beep_cnt_next = '0;
                    tone_next     = moc_pkg::TONE_PAUSE;
                    state_next    = moc_pkg::ST_IDLE;
                end
                if (evt.start_evt) begin
                    tick_next     = '0;
                    beep_on_next  = 1'b1;
                    beep_cnt_next = '0;
                    tone_next     = moc_pkg::TONE_START;
                    state_next    = moc_pkg::ST_RUN;
                end
            end
        endcase

        result_next.segments      = toggle_next ? moc_pkg::mode_pattern(mode_next)
                                                : moc_pkg::digit_pattern(secs_next);
        result_next.digit_select  = toggle_next;
        result_next.power_leds    = moc_pkg::power_pattern(power_next);
        result_next.mode_leds     = 4'd1 << mode_next;
        result_next.buzzer_on     = beep_on_next;
        result_next.buzzer_period = tone_next;
        result_next.cook_state    = state_next;
        result_next.time_left     = secs_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= moc_pkg::ST_IDLE;
            power_reg    <= moc_pkg::PWR_LOW;
            secs_reg     <= moc_pkg::SECONDS_RESET;
            mode_reg     <= '0;
            last_sw_reg  <= '0;
            tick_reg     <= '0;
            beep_cnt_reg <= '0;
            beep_on_reg  <= 1'b0;
            tone_reg     <= moc_pkg::TONE_START;
            toggle_reg   <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            if (pop) begin
                state_reg    <= state_next;
                power_reg    <= power_next;
                secs_reg     <= secs_next;
                mode_reg     <= mode_next;
                last_sw_reg  <= last_sw_next;
                tick_reg     <= tick_next;
                beep_cnt_reg <= beep_cnt_next;
                beep_on_reg  <= beep_on_next;
                tone_reg     <= tone_next;
                toggle_reg   <= toggle_next;
                valid_reg    <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_secs_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        secs_reg <= moc_pkg::SECONDS_MAX)
        else $error("remaining time above nine seconds");
    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> valid_reg && (result_reg.time_left == secs_reg))
        else $error("accepted event did not produce a result");
    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> $stable(state_reg) && $stable(secs_reg) && $stable(toggle_reg))
        else $error("controller state moved without an event");
    a_display_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> result_reg.digit_select == toggle_reg)
        else $error("digit select out of step with multiplexer");
`endif

endmodule

@@ rtl/microwave_oven_controller.sv @@
// ---------------------------------------------------------------------------
// Microwave oven controller
// Button debouncing, cooking timer, beeper and display drive, one tick per
// request.
// ---------------------------------------------------------------------------
// Each input request is one millisecond tick and yields exactly one result
// request. The block takes one tick every clock cycle when the result side
// keeps up; an accepted tick passes through the event queue and then the
// output register. The front end debounces the buttons as ticks arrive, and
// the queue lets it run ahead of a stalled output by up to its depth. The
// user must write configuration registers through the write port only while
// no tick is in flight; the block itself does not enforce this.
module microwave_oven_controller #(
    parameter int FIFO_DEPTH = moc_pkg::FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_level, pause_level, mode_switch[1:0], power_press, zero fill
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // segments[6:0], digit_select, power_leds[2:0], mode_leds[3:0], buzzer_on,
    // buzzer_period[7:0], cook_state[1:0], time_left[3:0], zero fill
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_wdata
);

    logic [7:0]          debounce_reg;
    logic [9:0]          tps_reg;
    logic [9:0]          beep_reg;
    logic [3:0][3:0]     preset_reg;
    moc_pkg::back_cfg_t  back_cfg;
    moc_pkg::evt_t       front_evt;
    moc_pkg::evt_t       queue_evt;
    moc_pkg::result_t    result;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= moc_pkg::DEBOUNCE_RESET;
            tps_reg       <= moc_pkg::TPS_RESET;
            beep_reg      <= moc_pkg::BEEP_RESET;
            preset_reg[0] <= moc_pkg::PRESET_QUICK_RESET;
            preset_reg[1] <= moc_pkg::PRESET_POPCORN_RESET;
            preset_reg[2] <= moc_pkg::PRESET_BEVERAGE_RESET;
            preset_reg[3] <= moc_pkg::PRESET_DEFROST_RESET;
        end else if (cfg_we) begin
            case (moc_pkg::cfg_reg_t'(cfg_index))
                moc_pkg::CFG_DEBOUNCE_TICKS:   debounce_reg  <= cfg_wdata[7:0];
                moc_pkg::CFG_TICKS_PER_SECOND: tps_reg       <= cfg_wdata;
                moc_pkg::CFG_BEEP_TICKS:       beep_reg      <= cfg_wdata;
                moc_pkg::CFG_PRESET_QUICK:     preset_reg[0] <= cfg_wdata[3:0];
                moc_pkg::CFG_PRESET_POPCORN:   preset_reg[1] <= cfg_wdata[3:0];
                moc_pkg::CFG_PRESET_BEVERAGE:  preset_reg[2] <= cfg_wdata[3:0];
                moc_pkg::CFG_PRESET_DEFROST:   preset_reg[3] <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign back_cfg.ticks_per_second = tps_reg;
    assign back_cfg.beep_ticks       = beep_reg;
    assign back_cfg.preset           = preset_reg;

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    moc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push           (push),
        .start_level    (s_tdata[0]),
        .pause_level    (s_tdata[1]),
        .mode_switch    (s_tdata[3:2]),
        .power_press    (s_tdata[4]),
        .debounce_ticks (debounce_reg),
        .evt            (front_evt)
    );

    moc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_evt),
        .pop       (pop),
        .pop_data  (queue_evt),
        .full      (full),
        .empty     (empty)
    );

    moc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt_avail (!empty),
        .evt       (queue_evt),
        .pop       (pop),
        .cfg       (back_cfg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    assign m_tdata = {2'b00, result};

endmodule
